[hw/rtl/modexp_pkg.sv]
package modexp_pkg;

    // Port width of base, exponent, modulus and result.
    localparam int PORT_W = 32;
    // Operand width of the arithmetic (range 8 to 64).
    localparam int OP_W   = 32;
    // Bit counter width of the shift-add-reduce unit.
    localparam int CNT_W  = (OP_W > 1) ? $clog2(OP_W) : 1;

    typedef logic [PORT_W-1:0] port_word_t;
    typedef logic [OP_W-1:0]   op_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_POW_WR,
        ST_TEST,
        ST_MUL_ACC,
        ST_ACC_WR,
        ST_MUL_SQR,
        ST_SQR_WR,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture a new beat, start base reduction
        logic start_acc;  // multiplier <- acc * pow
        logic start_sqr;  // multiplier <- pow * pow
        logic step;       // one shift-add-reduce step
        logic wr_acc;     // acc <- product
        logic wr_pow;     // pow <- product
        logic shift_exp;  // consume one exponent bit
        logic wr_out;     // result register <- acc
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic n_zero;        // modulus is zero
        logic exp_zero;      // no exponent bits left
        logic exp_lsb;       // current exponent bit
        logic exp_rest_zero; // no set bits above the current one
        logic mul_last;      // final step of a multiplication
    } dp_status_t;

    // Zero-extend or truncate a port word to operand width.
    function automatic op_word_t to_op(input port_word_t x);
        op_word_t r;
        r = '0;
        for (int i = 0; i < OP_W; i++) begin
            if (i < PORT_W) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    // Zero-extend or truncate an operand word to port width.
    function automatic port_word_t to_port(input op_word_t x);
        port_word_t r;
        r = '0;
        for (int i = 0; i < PORT_W; i++) begin
            if (i < OP_W) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/modexp_dp.sv]
module modexp_dp
    import modexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  port_word_t cfg_wr_data,
    input  port_word_t base,
    input  port_word_t exponent,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output port_word_t power_result
);

    port_word_t       modulus_reg;
    op_word_t         acc_reg, acc_next;
    op_word_t         pow_reg, pow_next;
    op_word_t         exp_reg, exp_next;
    op_word_t         mx_reg, mx_next;
    op_word_t         my_reg, my_next;
    op_word_t         r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    port_word_t       result_reg, result_next;

    op_word_t         n;
    op_word_t         one;
    logic [OP_W+2:0]  t, n1, n2, d1, d2;
    op_word_t         step_r;

    assign n   = to_op(modulus_reg);
    assign one = {{(OP_W-1){1'b0}}, (n > op_word_t'(1))};

    // 2r + bit*x < 3n: pick t, t-n or t-2n from parallel subtracts.
    assign t  = {2'b00, r_reg, 1'b0} + (my_reg[OP_W-1] ? {3'b000, mx_reg} : '0);
    assign n1 = {3'b000, n};
    assign n2 = {2'b00, n, 1'b0};
    assign d1 = t - n1;
    assign d2 = t - n2;

    always_comb
    begin
        if (!d2[OP_W+2]) begin
            step_r = d2[OP_W-1:0];
        end else if (!d1[OP_W+2]) begin
            step_r = d1[OP_W-1:0];
        end else begin
            step_r = t[OP_W-1:0];
        end
    end

    always_comb
    begin
        acc_next    = acc_reg;
        pow_next    = pow_reg;
        exp_next    = exp_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        r_next      = r_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;

        if (cmd.load) begin
            // base mod n computed as one * base
            acc_next = one;
            exp_next = to_op(exponent);
            mx_next  = one;
            my_next  = to_op(base);
            r_next   = '0;
            cnt_next = '0;
        end
        if (cmd.start_acc) begin
            mx_next  = acc_reg;
            my_next  = pow_reg;
            r_next   = '0;
            cnt_next = '0;
        end
        if (cmd.start_sqr) begin
            mx_next  = pow_reg;
            my_next  = pow_reg;
            r_next   = '0;
            cnt_next = '0;
        end
        if (cmd.step) begin
            r_next   = step_r;
            my_next  = {my_reg[OP_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.wr_acc) begin
            acc_next = r_reg;
        end
        if (cmd.wr_pow) begin
            pow_next = r_reg;
        end
        if (cmd.shift_exp) begin
            exp_next = {1'b0, exp_reg[OP_W-1:1]};
        end
        if (cmd.wr_out) begin
            result_next = to_port(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            modulus_reg <= port_word_t'(1);
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        pow_reg    <= pow_next;
        exp_reg    <= exp_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        r_reg      <= r_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign status.n_zero        = (n == '0);
    assign status.exp_zero      = (exp_reg == '0);
    assign status.exp_lsb       = exp_reg[0];
    assign status.exp_rest_zero = (exp_reg[OP_W-1:1] == '0);
    assign status.mul_last      = (cnt_reg == CNT_W'(OP_W-1));

    assign power_result = result_reg;

endmodule

[hw/rtl/modexp_ctrl.sv]
module modexp_ctrl
    import modexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    // zero modulus: acc loads as zero, nothing to compute
                    state_next = status.n_zero ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.step = 1'b1;
                if (status.mul_last) begin
                    state_next = ST_POW_WR;
                end
            end
            ST_POW_WR:
            begin
                cmd.wr_pow = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                priority if (status.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (status.exp_lsb) begin
                    cmd.start_acc = 1'b1;
                    state_next    = ST_MUL_ACC;
                end else begin
                    cmd.start_sqr = 1'b1;
                    state_next    = ST_MUL_SQR;
                end
            end
            ST_MUL_ACC:
            begin
                cmd.step = 1'b1;
                if (status.mul_last) begin
                    state_next = ST_ACC_WR;
                end
            end
            ST_ACC_WR:
            begin
                cmd.wr_acc = 1'b1;
                if (status.exp_rest_zero) begin
                    // top bit done; the last squaring is never used
                    cmd.shift_exp = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.start_sqr = 1'b1;
                    state_next    = ST_MUL_SQR;
                end
            end
            ST_MUL_SQR:
            begin
                cmd.step = 1'b1;
                if (status.mul_last) begin
                    state_next = ST_SQR_WR;
                end
            end
            ST_SQR_WR:
            begin
                cmd.wr_pow    = 1'b1;
                cmd.shift_exp = 1'b1;
                state_next    = ST_TEST;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready) begin
                    cmd.wr_out     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/modular_exponentiation.sv]
// Modular exponentiation: each input beat (base, exponent) yields one output
// beat power_result = base^exponent mod modulus, always fully reduced; an
// exponent of zero gives 1 mod modulus, and a modulus of 0 or 1 gives 0.
// The modulus is a single register written through cfg_wr_en/cfg_wr_data
// (reset value 1); write it only while the block is idle. Items are handled
// one at a time: the exponent is scanned LSB first (right-to-left
// square-and-multiply), and every modular product runs through one
// bit-serial shift-add-reduce unit that takes OP_W steps plus a write-back.
// An item passes through an accept, the base reduction, a test per exponent
// bit, a multiply per set bit and a squaring per bit (the squaring after the
// top bit is skipped), and a finish step. The finish step is held while an
// earlier result still waits for out_ready. The result sits in an output
// register, so a new beat is taken while the previous result still waits
// for out_ready.

module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // modulus register write
    input  logic       cfg_wr_en,
    input  port_word_t cfg_wr_data,

    // input beat
    input  logic       in_valid,
    output logic       in_ready,
    input  port_word_t base,
    input  port_word_t exponent,

    // output beat
    output logic       out_valid,
    input  logic       out_ready,
    output port_word_t power_result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: walks reduction, multiply and square phases per exponent bit.
    modexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Operand registers, modulus register, shift-add-reduce unit, result reg.
    modexp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .base         (base),
        .exponent     (exponent),
        .cmd          (cmd),
        .status       (status),
        .power_result (power_result)
    );

endmodule
